[rtl/float_sample_to_pcm_converter_unit_macros.svh]
// Assertion macros for the float sample to PCM converter.
`ifndef FLOAT_SAMPLE_TO_PCM_CONVERTER_UNIT_MACROS_SVH
`define FLOAT_SAMPLE_TO_PCM_CONVERTER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define FSPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define FSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FSPC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/fspc_pkg.sv]
// Constants for the float sample to PCM converter.
`default_nettype none
package fspc_pkg;
	// output format codes
	localparam logic [2:0] FMT_INT16   = 3'd0;
	localparam logic [2:0] FMT_INT24   = 3'd1;
	localparam logic [2:0] FMT_INT32   = 3'd2;
	localparam logic [2:0] FMT_FLOAT32 = 3'd3;
	localparam logic [2:0] FMT_FLOAT64 = 3'd4;

	// register indexes
	localparam logic REG_OUT_FORMAT    = 1'b0;
	localparam logic REG_LITTLE_ENDIAN = 1'b1;

	// full scale plus 0.49999 as double significands (53 bits, hidden bit set)
	localparam logic [52:0] SCALE16_MANT = 53'((64'd32767 << 38) + 64'd137436204693);
	localparam logic [52:0] SCALE24_MANT = 53'((64'd8388607 << 30) + 64'd536860175);
	localparam logic [52:0] SCALE32_MANT = 53'((64'd2147483647 << 22) + 64'd2097110);

	// right shift of the rounded product is BIAS - exponent - product top bit
	localparam logic [7:0] SCALE16_BIAS = 8'd165;
	localparam logic [7:0] SCALE24_BIAS = 8'd157;
	localparam logic [7:0] SCALE32_BIAS = 8'd149;
endpackage
`default_nettype wire

[rtl/float_sample_to_pcm_converter_unit.sv]
// Float32 audio sample to int16/int24/int32/float32/float64 converter, top level.
`default_nettype none
// Four register stages, one item per clock unless the output stalls: input capture,
// split multiply and float64 widening, product add and round to double, then shift,
// saturate and pack into the output register. An accepted item passes stage 1,
// stage 2 and stage 3 into the output register, which drives out_valid; an item may
// enter every cycle while no stall holds. A stall on the output holds a full stage
// only while every later stage is full too, so in_stall follows out_stall in the
// same cycle only once every stage holds an item. The 24 x 53 bit scale multiply,
// split into 24 x 27 and 24 x 26 halves, sets the stage split.
// Configuration is sampled as an item enters; write it only while idle.
`include "float_sample_to_pcm_converter_unit_macros.svh"
module float_sample_to_pcm_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [2:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] sample_bits,
	input  logic        last_sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] out_bytes,
	output logic [3:0]  byte_count,
	output logic        last_out
);
	import fspc_pkg::*;

	// position of the leading one in a subnormal mantissa
	function automatic logic [4:0] lead_pos(input logic [22:0] m);
		logic [4:0] p;
		p = 5'd0;
		for (int i = 0; i < 23; i++) begin
			if (m[i]) p = 5'(i);
		end
		return p;
	endfunction

	logic [2:0] out_format_q;
	logic       little_endian_q;

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic        rdy1, rdy2, rdy3, rdy4;

	// stage 1
	logic        sign_s1, last_s1, le_s1;
	logic [7:0]  exp_s1;
	logic [22:0] man_s1;
	logic [2:0]  fmt_s1;
	// stage 2
	logic        sign_s2, last_s2, le_s2, nan_s2;
	logic [7:0]  exp_s2, bias_s2;
	logic [2:0]  fmt_s2;
	logic [50:0] pp_lo_s2;
	logic [49:0] pp_hi_s2;
	logic [63:0] pass_s2;
	// stage 3
	logic        sign_s3, last_s3, le_s3, nan_s3;
	logic [2:0]  fmt_s3;
	logic [53:0] r_s3;
	logic signed [9:0] t_s3;
	logic [63:0] pass_s3;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_format_q    <= FMT_INT16;
			little_endian_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OUT_FORMAT:    out_format_q    <= cfg_wdata;
				REG_LITTLE_ENDIAN: little_endian_q <= cfg_wdata[0];
				default:           ;
			endcase
		end
	end

	// per-stage flow control
	assign rdy4     = !valid_s4 || !out_stall;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: capture item and configuration
	always_ff @(posedge clk) begin
		if (rdy1) begin
			sign_s1 <= sample_bits[31];
			exp_s1  <= sample_bits[30:23];
			man_s1  <= sample_bits[22:0];
			last_s1 <= last_sample;
			fmt_s1  <= out_format_q;
			le_s1   <= little_endian_q;
		end
	end

	// stage A: scale select, split multiply, float64 widening
	logic [52:0] scale_a;
	logic [7:0]  bias_a;
	logic [23:0] mant24_a;
	logic [50:0] pp_lo_a;
	logic [49:0] pp_hi_a;
	logic [63:0] dbl_a;
	logic [4:0]  lp_a, shifts_a;
	logic [23:0] norm_a;

	always_comb begin
		case (fmt_s1)
			FMT_INT16: begin
				scale_a = SCALE16_MANT;
				bias_a  = SCALE16_BIAS;
			end
			FMT_INT24: begin
				scale_a = SCALE24_MANT;
				bias_a  = SCALE24_BIAS;
			end
			default: begin
				scale_a = SCALE32_MANT;
				bias_a  = SCALE32_BIAS;
			end
		endcase
		mant24_a = {1'b1, man_s1};
		pp_lo_a  = 51'(mant24_a) * 51'(scale_a[26:0]);
		pp_hi_a  = 50'(mant24_a) * 50'(scale_a[52:27]);

		lp_a     = lead_pos(man_s1);
		shifts_a = 5'd23 - lp_a;
		norm_a   = 24'(man_s1) << shifts_a;
		if (exp_s1 == 8'hFF) begin
			dbl_a = {sign_s1, 11'h7FF, man_s1, 29'b0};
		end else if (exp_s1 == 8'h00) begin
			if (man_s1 == 23'b0)
				dbl_a = {sign_s1, 63'b0};
			else
				dbl_a = {sign_s1, 11'(11'd897 - 11'(shifts_a)), norm_a[22:0], 29'b0};
		end else begin
			dbl_a = {sign_s1, 11'(11'(exp_s1) + 11'd896), man_s1, 29'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			sign_s2  <= sign_s1;
			last_s2  <= last_s1;
			le_s2    <= le_s1;
			nan_s2   <= (exp_s1 == 8'hFF) && (man_s1 != 23'b0);
			exp_s2   <= exp_s1;
			bias_s2  <= bias_a;
			fmt_s2   <= fmt_s1;
			pp_lo_s2 <= pp_lo_a;
			pp_hi_s2 <= pp_hi_a;
			pass_s2  <= (fmt_s1 == FMT_FLOAT32) ? {32'b0, sign_s1, exp_s1, man_s1} : dbl_a;
		end
	end

	// stage B: full product, round to 53 bits nearest even
	logic [76:0] p_b;
	logic        top_b;
	logic [53:0] r_b;
	logic signed [9:0] t_b;

	always_comb begin
		p_b   = (77'(pp_hi_s2) << 27) + 77'(pp_lo_s2);
		top_b = p_b[76];
		if (top_b)
			r_b = 54'(p_b[76:24]) + 54'(p_b[23] & ((p_b[22:0] != 23'b0) | p_b[24]));
		else
			r_b = 54'(p_b[75:23]) + 54'(p_b[22] & ((p_b[21:0] != 22'b0) | p_b[23]));
		t_b = $signed({2'b0, bias_s2}) - $signed({2'b0, exp_s2}) - $signed({9'b0, top_b});
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			sign_s3 <= sign_s2;
			last_s3 <= last_s2;
			le_s3   <= le_s2;
			nan_s3  <= nan_s2;
			fmt_s3  <= fmt_s2;
			r_s3    <= r_b;
			t_s3    <= t_b;
			pass_s3 <= pass_s2;
		end
	end

	// stage C: truncate, saturate, format and pack
	logic [32:0] mag_c, lim_c, clamp_c, ival_c;
	logic        sat_c;
	logic [63:0] val_c, pack_c;
	logic [3:0]  cnt_c;

	always_comb begin
		sat_c = 1'b0;
		mag_c = 33'b0;
		if (t_s3 < 10'sd22)
			sat_c = 1'b1;
		else if (t_s3 < 10'sd64)
			mag_c = 33'(r_s3 >> t_s3[5:0]);

		case (fmt_s3)
			FMT_INT16: lim_c = 33'h0_0000_8000;
			FMT_INT24: lim_c = 33'h0_0080_0000;
			default:   lim_c = 33'h0_8000_0000;
		endcase

		// positive tops out at lim-1, negative at lim
		if (sign_s3)
			clamp_c = (sat_c || mag_c > lim_c) ? lim_c : mag_c;
		else
			clamp_c = (sat_c || mag_c >= lim_c) ? lim_c - 33'd1 : mag_c;
		if (nan_s3)
			ival_c = 33'b0;
		else
			ival_c = sign_s3 ? (~clamp_c + 33'd1) : clamp_c;

		case (fmt_s3)
			FMT_INT16: begin
				val_c = {48'b0, ival_c[15:0]};
				cnt_c = 4'd2;
			end
			FMT_INT24: begin
				val_c = {40'b0, ival_c[23:0]};
				cnt_c = 4'd3;
			end
			FMT_INT32: begin
				val_c = {32'b0, ival_c[31:0]};
				cnt_c = 4'd4;
			end
			FMT_FLOAT32: begin
				val_c = pass_s3;
				cnt_c = 4'd4;
			end
			default: begin
				val_c = pass_s3;
				cnt_c = 4'd8;
			end
		endcase

		// byte order within the valid bytes
		if (le_s3) begin
			pack_c = val_c;
		end else begin
			case (cnt_c)
				4'd2:    pack_c = {48'b0, val_c[7:0], val_c[15:8]};
				4'd3:    pack_c = {40'b0, val_c[7:0], val_c[15:8], val_c[23:16]};
				4'd4:    pack_c = {32'b0, val_c[7:0], val_c[15:8], val_c[23:16],
					val_c[31:24]};
				default: pack_c = {val_c[7:0], val_c[15:8], val_c[23:16], val_c[31:24],
					val_c[39:32], val_c[47:40], val_c[55:48], val_c[63:56]};
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (rdy4) begin
			out_bytes  <= pack_c;
			byte_count <= cnt_c;
			last_out   <= last_s3;
		end
	end

	assign out_valid = valid_s4;

	// checks
	`FSPC_ASSERT_IMPL(a_count_legal, clk, arst_n, out_valid, (byte_count == 4'd2 || byte_count == 4'd3 || byte_count == 4'd4 || byte_count == 4'd8))
	`FSPC_ASSERT_IMPL(a_upper_clear, clk, arst_n, out_valid && byte_count != 4'd8, out_bytes[63:32] == 32'b0)
	`FSPC_ASSERT_NEXT(a_accept_lands, clk, arst_n, in_valid && !in_stall, valid_s1)
endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the float sample to PCM converter: random and directed samples.
`timescale 1ns / 100ps
module tb_top;
	import fspc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int PIPE_DRAIN  = 8;

	typedef struct packed {
		logic [31:0] bits;
		logic        last;
	} sample_t;

	typedef struct packed {
		logic [63:0] bytes;
		logic [3:0]  count;
		logic        last;
	} pcm_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [2:0]  cfg_wdata = 3'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] sample_bits = 32'd0;
	logic        last_sample = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] out_bytes;
	logic [3:0]  byte_count;
	logic        last_out;

	sample_t pending_samples[$];
	pcm_t    expected_pcm[$];
	int      errors = 0;
	int      cycles = 0;
	int      send_idle_pct = 0;
	int      stall_pct = 0;
	int      hold_request = 0;
	int      hold_served = 0;
	int      hold_left = 0;
	logic [2:0] fmt_sel = FMT_INT16;
	logic    le_sel = 1'b1;

	float_sample_to_pcm_converter_unit dut (.*);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// exact single to double widening
	function automatic logic [63:0] widen(input logic [31:0] b);
		logic [63:0] sgn;
		logic [7:0]  ex;
		logic [22:0] man;
		int          sh;
		sgn = {b[31], 63'd0};
		ex = b[30:23];
		man = b[22:0];
		sh = 0;
		if (ex == 8'hff)
			return sgn | (64'h7ff << 52) | (64'(man) << 29);
		if (ex == 8'd0) begin
			if (man == 23'd0)
				return sgn;
			// normalise the subnormal significand
			while (man[22] == 1'b0) begin
				man = man << 1;
				sh++;
			end
			man = man << 1;
			return sgn | (64'(896 - sh) << 52) | (64'(man) << 29);
		end
		return sgn | (64'(ex + 896) << 52) | (64'(man) << 29);
	endfunction

	// scale, truncate and saturate to a signed integer format
	function automatic longint to_pcm_int(input logic [31:0] b, input real fs,
			input longint maxv, input longint minv);
		real v;
		if (b[30:23] == 8'hff && b[22:0] != 23'd0)
			return 0;
		v = $bitstoreal(widen(b)) * fs;
		if (v >= real'(maxv) + 1.0)
			return maxv;
		if (v <= real'(minv) - 1.0)
			return minv;
		return longint'($rtoi(v));
	endfunction

	// expected converted and packed item
	function automatic pcm_t convert_sample(input sample_t s);
		pcm_t        r;
		logic [63:0] val;
		int          n;
		case (fmt_sel)
			FMT_INT16: begin
				val = 64'(to_pcm_int(s.bits, 32767.0 + 0.49999, 32767, -32768)) & 64'hffff;
				n = 2;
			end
			FMT_INT24: begin
				val = 64'(to_pcm_int(s.bits, 8388607.0 + 0.49999, 8388607, -8388608))
					& 64'hffffff;
				n = 3;
			end
			FMT_INT32: begin
				val = 64'(to_pcm_int(s.bits, 2147483647.0 + 0.49999, 2147483647,
					-2147483647 - 1)) & 64'hffffffff;
				n = 4;
			end
			FMT_FLOAT32: begin
				val = 64'(s.bits);
				n = 4;
			end
			default: begin
				val = widen(s.bits);
				n = 8;
			end
		endcase
		r.bytes = 64'd0;
		for (int i = 0; i < n; i++)
			r.bytes[8 * (le_sel ? i : n - 1 - i) +: 8] = val[8 * i +: 8];
		r.count = 4'(n);
		r.last = s.last;
		return r;
	endfunction

	// sender
	always @(posedge clk) begin
		if (arst_n && (!in_valid || !in_stall)) begin
			if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				sample_t s;
				s = pending_samples.pop_front();
				sample_bits <= s.bits;
				last_sample <= s.last;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// expectation on each accepted item
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			expected_pcm.push_back(convert_sample('{sample_bits, last_sample}));
	end

	// receiver stall, with a long hold when requested
	always @(posedge clk) begin
		if (hold_request != hold_served) begin
			hold_served <= hold_request;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pcm.size() == 0) begin
				$display("%0t: unexpected item bytes=%h count=%0d last=%b",
					$time, out_bytes, byte_count, last_out);
				errors++;
			end else begin
				pcm_t e;
				e = expected_pcm.pop_front();
				if (out_bytes !== e.bytes) begin
					$display("%0t: out_bytes expected %h actual %h", $time, e.bytes, out_bytes);
					errors++;
				end
				if (byte_count !== e.count) begin
					$display("%0t: byte_count expected %0d actual %0d",
						$time, e.count, byte_count);
					errors++;
				end
				if (last_out !== e.last) begin
					$display("%0t: last_out expected %b actual %b", $time, e.last, last_out);
					errors++;
				end
			end
		end
	end

	// random sample, weighted to the nominal range with specials mixed in
	function automatic logic [31:0] random_bits();
		logic        sgn;
		logic [22:0] man;
		sgn = 1'($urandom_range(1));
		man = 23'($urandom);
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return {sgn, 8'($urandom_range(100, 127)), man};
			5:             return {sgn, 8'($urandom_range(126, 128)), man};
			6:             return $urandom;
			7:             return {sgn, 8'd0, man};
			8:             return {sgn, 8'hff, ($urandom_range(3) == 0) ? 23'd0 : man};
			default:       return {sgn, 8'($urandom_range(128, 254)), man};
		endcase
	endfunction

	// checked away from the rising edge so that queue and handshake updates have settled
	task automatic wait_drained();
		@(negedge clk);
		while (pending_samples.size() > 0 || in_valid || expected_pcm.size() > 0)
			@(negedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic set_config(input logic [2:0] fmt, input logic le);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_OUT_FORMAT;
		cfg_wdata <= fmt;
		@(posedge clk);
		cfg_index <= REG_LITTLE_ENDIAN;
		cfg_wdata <= {2'b00, le};
		@(posedge clk);
		cfg_we <= 1'b0;
		fmt_sel = fmt;
		le_sel = le;
	endtask

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++)
			pending_samples.push_back('{random_bits(), 1'($urandom_range(7) == 0)});
	endtask

	// stimulus
	initial begin
		logic [31:0] directed[$];
		logic [2:0]  fmts[10];
		logic        les[10];
		directed = '{32'h0000_0000, 32'h8000_0000, 32'h3f80_0000, 32'hbf80_0000,
			32'h7f80_0000, 32'hff80_0000, 32'h7fc0_0000, 32'h7f80_0001, 32'hffff_ffff,
			32'h0000_0001, 32'h807f_ffff, 32'h7f7f_ffff, 32'hff7f_ffff, 32'h3f00_0000,
			32'hbf7f_ffff, 32'h3f7f_ffff, 32'h3380_0000, 32'h4000_0000, 32'h3effffff,
			32'h0040_0000};
		fmts = '{FMT_INT16, FMT_INT24, FMT_INT32, FMT_FLOAT32, FMT_FLOAT64,
			FMT_FLOAT64, 3'd7, 3'd5, FMT_INT32, FMT_INT16};
		les = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < 10; p++) begin
			wait_drained();
			set_config(fmts[p], les[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 55; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 55; end
				default: begin send_idle_pct = 27; stall_pct = 27; end
			endcase
			// directed extremes and special cases, each format in turn
			foreach (directed[i])
				pending_samples.push_back('{directed[i], 1'(i == directed.size() - 1)});
			if (p == 2) begin
				// long receiver hold while the sender keeps offering items
				hold_request++;
				queue_random(40);
				queue_random(20);
			end else if (p == 3) begin
				// sender pause until the pipeline has emptied
				queue_random(30);
				wait_drained();
				queue_random(30);
			end else begin
				queue_random(60);
			end
		end

		wait_drained();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

[float_sample_to_pcm_converter_unit.f]
+incdir+rtl
rtl/fspc_pkg.sv
rtl/float_sample_to_pcm_converter_unit.sv
bench/tb_top.sv
